>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the quadtree node select RTL
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset
`define LQNS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define LQNS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/lqns_pkg.sv
// ----------------------------------------------------------------------------
// lqns_pkg
// Types, constants and helpers for the loose quadtree node select core.
// ----------------------------------------------------------------------------
package lqns_pkg;

    localparam int FRAC_W   = 4;
    localparam int MIN_W    = 10;
    localparam int MAX_W    = 12;
    localparam int Y_W      = 16;
    localparam int CELL_W   = MIN_W - FRAC_W;
    localparam int CELLS    = 2 ** CELL_W;
    localparam int LEVEL_W  = 3;
    localparam int NODE_W   = 9;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_Y_LIMIT_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_LIMIT_HIGH = 2'd1;

    localparam logic signed [Y_W-1:0] Y_LIMIT_LOW_RST  = 16'sd0;
    localparam logic signed [Y_W-1:0] Y_LIMIT_HIGH_RST = 16'sd256;

    typedef struct packed {
        logic [MIN_W-1:0]        box_min_x;
        logic [MIN_W-1:0]        box_min_z;
        logic [MAX_W-1:0]        box_max_x;
        logic [MAX_W-1:0]        box_max_z;
        logic signed [Y_W-1:0]   box_min_y;
        logic signed [Y_W-1:0]   box_max_y;
    } in_item_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [NODE_W-1:0]  node_number;
    } out_item_t;

    // first stage: whole-cell corner and clamped y extent
    typedef struct packed {
        logic [MIN_W-1:0]        min_x;
        logic [MIN_W-1:0]        min_z;
        logic [MAX_W-1:0]        max_x;
        logic [MAX_W-1:0]        max_z;
        logic [CELL_W-1:0]       cell_x;
        logic [CELL_W-1:0]       cell_z;
        logic signed [Y_W-1:0]   min_y;
        logic signed [Y_W-1:0]   max_y;
    } front_t;

    // box extent handed to every level unit
    typedef struct packed {
        logic [MIN_W-1:0] min_x;
        logic [MIN_W-1:0] min_z;
        logic [MAX_W-1:0] max_x;
        logic [MAX_W-1:0] max_z;
        logic             y_ok;
    } geo_t;

    // index of the first node of a level: 1 + 4 + 16 + ...
    function automatic int level_base(input int lvl);
        int b;
        int p;
        b = 0;
        p = 1;
        for (int i = 0; i < 8; i++) begin
            if (i < lvl) begin
                b = b + p;
                p = p * 4;
            end
        end
        return b;
    endfunction

endpackage

>>> rtl/core/loose_quadtree_node_select_core.sv
// ----------------------------------------------------------------------------
// loose_quadtree_node_select_core
// Pipeline: front, node lookup, loose-bound test and deepest-level select,
// one register stage each, from input accept to result valid. Throughput:
// one item per cycle while not stalled; every level is tested side by side.
// Reset: synchronous active low; clears the valid chain and sets the y limits
// to 0 and 256. A stall on the result side holds every stage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module loose_quadtree_node_select_core import lqns_pkg::*; #(
    parameter int MAP_EXTENT = 64,
    parameter int LEVELS     = 5
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_item_t             s_item,

    output logic                 m_valid,
    input  logic                 m_ready,
    output out_item_t            m_item,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [Y_W-1:0]       cfg_data
);

    logic                  en;
    logic signed [Y_W-1:0] y_low_reg;
    logic signed [Y_W-1:0] y_high_reg;
    logic                  v1_reg;
    logic                  v2_reg;
    logic                  v3_reg;
    logic                  m_valid_reg;
    front_t                front_reg;
    geo_t                  geo_reg;
    geo_t                  geo_next;
    logic [LEVELS-1:1]     fits_vec;
    logic [NODE_W-1:0]     node_lvl [1:LEVELS-1];
    out_item_t             out_reg;
    out_item_t             out_next;

    // whole pipe advances unless a finished item waits
    assign en        = !m_valid_reg || m_ready;
    assign s_ready   = en;
    assign m_valid   = m_valid_reg;
    assign m_item    = out_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            y_low_reg  <= Y_LIMIT_LOW_RST;
            y_high_reg <= Y_LIMIT_HIGH_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_Y_LIMIT_LOW:  y_low_reg  <= $signed(cfg_data);
                CFG_Y_LIMIT_HIGH: y_high_reg <= $signed(cfg_data);
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            v1_reg      <= s_valid;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            m_valid_reg <= v3_reg;
        end
    end

    lqns_front #(
        .MAP_EXTENT (MAP_EXTENT)
    ) u_front (
        .aclk      (aclk),
        .en        (en),
        .item      (s_item),
        .y_low     (y_low_reg),
        .y_high    (y_high_reg),
        .front_reg (front_reg)
    );

    always_comb begin
        geo_next.min_x = front_reg.min_x;
        geo_next.min_z = front_reg.min_z;
        geo_next.max_x = front_reg.max_x;
        geo_next.max_z = front_reg.max_z;
        geo_next.y_ok  = (front_reg.min_y >= y_low_reg) && (front_reg.max_y <= y_high_reg);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            geo_reg <= geo_next;
        end
    end

    for (genvar d = 1; d < LEVELS; d++) begin : g_level
        lqns_level #(
            .DEPTH      (d),
            .MAP_EXTENT (MAP_EXTENT)
        ) u_level (
            .aclk     (aclk),
            .en       (en),
            .cell_x   (front_reg.cell_x),
            .cell_z   (front_reg.cell_z),
            .geo      (geo_reg),
            .fits_reg (fits_vec[d]),
            .node_reg (node_lvl[d])
        );
    end

    // deepest fitting level wins, root otherwise
    always_comb begin
        out_next.level       = '0;
        out_next.node_number = '0;
        for (int d = 1; d < LEVELS; d++) begin
            if (fits_vec[d]) begin
                out_next.level       = LEVEL_W'(d);
                out_next.node_number = node_lvl[d];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg <= out_next;
        end
    end

    `LQNS_ASSERT_NEXT(a_accept_enters, aclk, aresetn, s_valid && s_ready, v1_reg,
        "accepted item did not enter the first stage")
    `LQNS_ASSERT_NOW(a_level_range, aclk, aresetn, m_valid, int'(m_item.level) < LEVELS,
        "result level beyond tree depth")
    `LQNS_ASSERT_NOW(a_root_node, aclk, aresetn, m_valid && (m_item.level == '0),
        m_item.node_number == '0, "root result with non-zero node")
    `LQNS_ASSERT_NOW(a_node_in_level, aclk, aresetn, m_valid,
        (int'(m_item.node_number) >= level_base(int'(m_item.level)))
        && (int'(m_item.node_number) < level_base(int'(m_item.level) + 1)),
        "node index outside its level")

endmodule

>>> rtl/core/lqns_front.sv
// ----------------------------------------------------------------------------
// lqns_front
// Input stage: truncates the min corner to whole cells and clamps the y range.
// ----------------------------------------------------------------------------
module lqns_front import lqns_pkg::*; #(
    parameter int MAP_EXTENT = 64
) (
    input  logic                  aclk,
    input  logic                  en,
    input  in_item_t              item,
    input  logic signed [Y_W-1:0] y_low,
    input  logic signed [Y_W-1:0] y_high,
    output front_t                front_reg
);

    logic [CELL_W-1:0] cell_x;
    logic [CELL_W-1:0] cell_z;
    front_t            front_next;

    always_comb begin
        cell_x = item.box_min_x[MIN_W-1:FRAC_W];
        cell_z = item.box_min_z[MIN_W-1:FRAC_W];
        // saturate a corner beyond the map to its last cell
        if (32'(cell_x) >= MAP_EXTENT) begin
            cell_x = CELL_W'(MAP_EXTENT - 1);
        end
        if (32'(cell_z) >= MAP_EXTENT) begin
            cell_z = CELL_W'(MAP_EXTENT - 1);
        end

        front_next.min_x  = item.box_min_x;
        front_next.min_z  = item.box_min_z;
        front_next.max_x  = item.box_max_x;
        front_next.max_z  = item.box_max_z;
        front_next.cell_x = cell_x;
        front_next.cell_z = cell_z;
        front_next.min_y  = (item.box_min_y < y_low)  ? y_low  : item.box_min_y;
        front_next.max_y  = (item.box_max_y > y_high) ? y_high : item.box_max_y;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            front_reg <= front_next;
        end
    end

endmodule

>>> rtl/core/lqns_level.sv
// ----------------------------------------------------------------------------
// lqns_level
// One tree depth: finds the node under the corner cell, tests the box against
// its loose bounds and forms the flat node index. Two register stages.
// ----------------------------------------------------------------------------
module lqns_level import lqns_pkg::*; #(
    parameter int DEPTH      = 1,
    parameter int MAP_EXTENT = 64
) (
    input  logic              aclk,
    input  logic              en,
    input  logic [CELL_W-1:0] cell_x,
    input  logic [CELL_W-1:0] cell_z,
    input  geo_t              geo,
    output logic              fits_reg,
    output logic [NODE_W-1:0] node_reg
);

    localparam int SIZE    = MAP_EXTENT >> DEPTH;
    localparam int BORDER  = SIZE / 4;
    localparam int LIM     = (1 << DEPTH) - 1;
    localparam int BOUND_W = $clog2((MAP_EXTENT + MAP_EXTENT / 4 + 1) * 16) + 1;
    localparam int BW      = (BOUND_W > MAX_W + 1) ? BOUND_W : MAX_W + 1;
    localparam int BASE    = level_base(DEPTH);

    // node coordinate for every cell, saturated to the last node
    function automatic logic [CELLS*DEPTH-1:0] build_coord();
        logic [CELLS*DEPTH-1:0] t;
        int n;
        t = '0;
        for (int c = 0; c < CELLS; c++) begin
            n = 0;
            for (int k = 1; k <= LIM; k++) begin
                if (c >= k * SIZE) begin
                    n = k;
                end
            end
            t[c*DEPTH +: DEPTH] = DEPTH'(n);
        end
        return t;
    endfunction

    localparam logic [CELLS*DEPTH-1:0] COORD = build_coord();

    logic [DEPTH-1:0]     nx_reg;
    logic [DEPTH-1:0]     nz_reg;
    logic [BW-1:0]        org_x;
    logic [BW-1:0]        org_z;
    logic signed [BW-1:0] lo_x;
    logic signed [BW-1:0] hi_x;
    logic signed [BW-1:0] lo_z;
    logic signed [BW-1:0] hi_z;
    logic                 fits_next;
    logic [NODE_W-1:0]    node_next;

    always_ff @(posedge aclk) begin
        if (en) begin
            nx_reg <= COORD[cell_x*DEPTH +: DEPTH];
            nz_reg <= COORD[cell_z*DEPTH +: DEPTH];
        end
    end

    always_comb begin
        org_x = BW'(nx_reg) * BW'(SIZE * 16);
        org_z = BW'(nz_reg) * BW'(SIZE * 16);
        lo_x  = $signed(org_x) - $signed(BW'(BORDER * 16));
        hi_x  = $signed(org_x) + $signed(BW'((SIZE + BORDER) * 16));
        lo_z  = $signed(org_z) - $signed(BW'(BORDER * 16));
        hi_z  = $signed(org_z) + $signed(BW'((SIZE + BORDER) * 16));

        fits_next = ($signed(BW'(geo.min_x)) >= lo_x) && ($signed(BW'(geo.max_x)) <= hi_x)
                 && ($signed(BW'(geo.min_z)) >= lo_z) && ($signed(BW'(geo.max_z)) <= hi_z)
                 && geo.y_ok;
        node_next = NODE_W'(BASE) + NODE_W'({nz_reg, nx_reg});
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fits_reg <= fits_next;
            node_reg <= node_next;
        end
    end

endmodule

>>> verif/lqns_node_checker.sv
// ----------------------------------------------------------------------------
// lqns_node_checker
// Watches the box, result and register channels of the node select core. It
// works out the expected level and node for every accepted box from its own
// copy of the y limits, and compares each accepted result in order.
// ----------------------------------------------------------------------------
module lqns_node_checker import lqns_pkg::*; #(
    parameter int MAP_EXTENT = 64,
    parameter int LEVELS     = 5
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_valid,
    input  logic                 s_ready,
    input  in_item_t             s_item,

    input  logic                 m_valid,
    input  logic                 m_ready,
    input  out_item_t            m_item,

    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [Y_W-1:0]       cfg_data,

    output int                   mismatches,
    output int                   pending
);

    int        y_low;
    int        y_high;
    out_item_t expected_nodes[$];
    int        open_count;
    int        fail_count;

    assign mismatches = fail_count;
    assign pending    = open_count;

    // Deepest level whose loose node holds the whole box, root otherwise
    function automatic out_item_t select_node(input in_item_t b, input int lo, input int hi);
        out_item_t r;
        int        minx, minz, maxx, maxz, miny, maxy;
        int        cx, cz, sz, brd, nx, nz, lim, first_node, p;
        int        x0, x1, z0, z1;
        bit        found, fits;
        r     = '0;
        found = 1'b0;
        minx  = b.box_min_x;
        minz  = b.box_min_z;
        maxx  = b.box_max_x;
        maxz  = b.box_max_z;
        miny  = $signed(b.box_min_y);
        maxy  = $signed(b.box_max_y);
        if (miny < lo) miny = lo;
        if (maxy > hi) maxy = hi;
        cx = minx >> FRAC_W;
        cz = minz >> FRAC_W;
        if (cx >= MAP_EXTENT) cx = MAP_EXTENT - 1;
        if (cz >= MAP_EXTENT) cz = MAP_EXTENT - 1;
        // index of the first node on the deepest level
        first_node = 0;
        p = 1;
        for (int i = 0; i < LEVELS - 1; i++) begin
            first_node = first_node + p;
            p = p * 4;
        end
        for (int d = LEVELS - 1; d > 0; d--) begin
            sz  = MAP_EXTENT >> d;
            brd = sz / 4;
            lim = (1 << d) - 1;
            nx  = cx / sz;
            nz  = cz / sz;
            if (nx > lim) nx = lim;
            if (nz > lim) nz = lim;
            x0 = (nx * sz - brd) * 16;
            z0 = (nz * sz - brd) * 16;
            x1 = (nx * sz + sz + brd) * 16;
            z1 = (nz * sz + sz + brd) * 16;
            fits = minx >= x0 && maxx <= x1 && minz >= z0 && maxz <= z1 &&
                   miny >= lo && maxy <= hi;
            if (!found && fits) begin
                found         = 1'b1;
                r.level       = d[LEVEL_W-1:0];
                r.node_number = NODE_W'(first_node + nz * (1 << d) + nx);
            end
            first_node = first_node - (1 << (2 * (d - 1)));
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            y_low  = $signed(Y_LIMIT_LOW_RST);
            y_high = $signed(Y_LIMIT_HIGH_RST);
            expected_nodes.delete();
            open_count = 0;
            fail_count = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_Y_LIMIT_LOW:  y_low  = $signed(cfg_data);
                    CFG_Y_LIMIT_HIGH: y_high = $signed(cfg_data);
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                expected_nodes.push_back(select_node(s_item, y_low, y_high));
                open_count = open_count + 1;
            end
            if (m_valid && m_ready) begin
                if (expected_nodes.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual level %0d node %0d",
                             $time, m_item.level, m_item.node_number);
                    fail_count = fail_count + 1;
                end else begin
                    want = expected_nodes.pop_front();
                    open_count = open_count - 1;
                    if (m_item.level !== want.level) begin
                        $display("%0t: level expected %0d actual %0d",
                                 $time, want.level, m_item.level);
                        fail_count = fail_count + 1;
                    end
                    if (m_item.node_number !== want.node_number) begin
                        $display("%0t: node_number expected %0d actual %0d",
                                 $time, want.node_number, m_item.node_number);
                        fail_count = fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

>>> verif/tb_loose_quadtree_node_select_core.sv
// ----------------------------------------------------------------------------
// tb_loose_quadtree_node_select_core
// Drives object boxes into the node select core under several y limit
// settings: a directed set on node edges and extremes, then random boxes,
// mostly sized to one level's node. Both channels idle in random bursts.
// ----------------------------------------------------------------------------
module tb_loose_quadtree_node_select_core import lqns_pkg::*; ();

    localparam int MAP_EXTENT  = 64;
    localparam int LEVELS      = 5;
    localparam int LATENCY     = 4;
    localparam int PHASE_ITEMS = 463;
    localparam int CALM_ITEMS  = 200;
    localparam int CYCLE_LIMIT = 200000;
    localparam logic [Y_W-1:0] Y_MOST_NEG = 16'h8000;
    localparam logic [Y_W-1:0] Y_MOST_POS = 16'h7fff;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    in_item_t             s_item    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    out_item_t            m_item;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_Y_LIMIT_LOW;
    logic [Y_W-1:0]       cfg_data  = '0;

    int mismatches;
    int pending;
    int idle_pct  = 0;
    int hold_left = 0;
    int cycles    = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    loose_quadtree_node_select_core #(
        .MAP_EXTENT (MAP_EXTENT),
        .LEVELS     (LEVELS)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    lqns_node_checker #(
        .MAP_EXTENT (MAP_EXTENT),
        .LEVELS     (LEVELS)
    ) u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_item     (m_item),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    // Result side back-pressure: m_ready held low in random bursts
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            m_ready   <= 1'b0;
            hold_left <= $urandom_range(7);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: timed out with %0d results outstanding", $time, pending);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic in_item_t box(input int mnx, input int mnz, input int mxx,
                                     input int mxz, input int mny, input int mxy);
        in_item_t b;
        b.box_min_x = mnx[MIN_W-1:0];
        b.box_min_z = mnz[MIN_W-1:0];
        b.box_max_x = mxx[MAX_W-1:0];
        b.box_max_z = mxz[MAX_W-1:0];
        b.box_min_y = mny[Y_W-1:0];
        b.box_max_y = mxy[Y_W-1:0];
        return b;
    endfunction

    // Mostly boxes sized to one level's node, some inverted, some wild
    task automatic draw_box(output in_item_t b);
        int kind, lvl, span, mnx, mnz, mxx, mxz;
        mnx  = $urandom_range(1023);
        mnz  = $urandom_range(1023);
        kind = $urandom_range(99);
        if (kind < 65) begin
            lvl  = $urandom_range(LEVELS - 1, 1);
            span = ((MAP_EXTENT >> lvl) * 16 * 3) / 2;
            mxx  = mnx + $urandom_range(span);
            mxz  = mnz + $urandom_range(span);
            if (mxx > 4095) mxx = 4095;
            if (mxz > 4095) mxz = 4095;
        end else if (kind < 78) begin
            mxx = $urandom_range(mnx);
            mxz = $urandom_range(mnz);
        end else begin
            mxx = $urandom_range(4095);
            mxz = $urandom_range(4095);
        end
        b = box(mnx, mnz, mxx, mxz, $urandom, $urandom);
    endtask

    // Call at a rising edge; returns at the edge where the item is taken
    task automatic send_box(input in_item_t b);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(8, 1)) @(posedge aclk);
        end
        s_item  <= b;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [Y_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic set_limits(input logic [Y_W-1:0] lo, input logic [Y_W-1:0] hi);
        if ($urandom_range(1) != 0) begin
            write_reg(CFG_Y_LIMIT_LOW, lo);
            write_reg(CFG_Y_LIMIT_HIGH, hi);
        end else begin
            write_reg(CFG_Y_LIMIT_HIGH, hi);
            write_reg(CFG_Y_LIMIT_LOW, lo);
        end
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic run_random(input int count, input bit calm_tail);
        in_item_t b;
        for (int i = 0; i < count; i++) begin
            if (calm_tail && i >= count - CALM_ITEMS) begin
                idle_pct = 0;
            end else if (i % 50 == 0) begin
                case ($urandom_range(2))
                    0:       idle_pct = 0;
                    1:       idle_pct = 15;
                    default: idle_pct = 45;
                endcase
            end
            draw_box(b);
            send_box(b);
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed set under reset limits
        idle_pct = 20;
        send_box(box(0, 0, 0, 0, 0, 0));
        send_box(box(0, 0, 80, 80, 0, 256));          // deepest loose edge, inclusive
        send_box(box(0, 0, 81, 80, 0, 256));          // one past it
        send_box(box(0, 0, 80, 81, 0, 256));
        send_box(box(1023, 1023, 1023, 1023, 0, 0));  // far corner node
        send_box(box(1023, 1023, 4095, 4095, 0, 0));
        send_box(box(0, 0, 4095, 4095, 10, 20));
        send_box(box(400, 400, 1152, 1152, 0, 0));    // level 1 node 1 loose edge; the corner cell lies in node 0
        send_box(box(400, 400, 1153, 1152, 0, 0));
        send_box(box(1000, 1000, 0, 0, 5, 1));        // inverted box
        send_box(box(100, 100, 120, 120, -32768, 32767));
        send_box(box(100, 100, 120, 120, 32767, -32768));
        send_box(box(1023, 0, 1023, 0, -1, 0));
        send_box(box(0, 1023, 16, 4095, 0, -1));
        send_box(box(64, 64, 64, 64, 0, 0));
        send_box(box(63, 63, 96, 96, 0, 0));          // straddles deepest nodes
        send_box(box(1023, 1023, 4095, 4095, -1, -1));
        send_box(box(512, 0, 767, 95, 300, 400));
        wait_idle();

        set_limits(Y_MOST_NEG, Y_MOST_POS);
        run_random(PHASE_ITEMS, 1'b0);
        wait_idle();

        set_limits(Y_MOST_POS, Y_MOST_NEG);
        run_random(PHASE_ITEMS, 1'b0);
        wait_idle();

        set_limits(Y_W'($urandom), Y_W'($urandom));
        run_random(PHASE_ITEMS, 1'b0);
        wait_idle();

        set_limits(Y_W'(-16), Y_W'(100));
        run_random(PHASE_ITEMS, 1'b1);
        wait_idle();

        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> loose_quadtree_node_select_core.f
+incdir+rtl/core
rtl/core/lqns_pkg.sv
rtl/core/lqns_front.sv
rtl/core/lqns_level.sv
rtl/core/loose_quadtree_node_select_core.sv
verif/lqns_node_checker.sv
verif/tb_loose_quadtree_node_select_core.sv
